// ===== hw/rtl/er_pkg.sv =====
`timescale 1ns / 1ps
// shared widths and codes for the ellipse rasterizer
// no dependencies

package er_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 10;

    localparam int PIX_W  = COORD_BITS + 1;
    localparam int CURX_W = RADIUS_BITS + 1;
    localparam int CURY_W = RADIUS_BITS + 2;
    localparam int SQ_W   = 2 * RADIUS_BITS;
    localparam int GRAD_W = 3 * RADIUS_BITS + 6;
    localparam int DEC_W  = 4 * RADIUS_BITS + 8;
    localparam int MOP_W  = 2 * RADIUS_BITS + 5;
    localparam int PROD_W = 2 * MOP_W;
    localparam int SUM_W  = COORD_BITS + CURY_W + 1;

    localparam int S_TDATA_W = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * PIX_W + 7) / 8) * 8;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

endpackage

// ===== hw/rtl/er_mul.sv =====
`timescale 1ns / 1ps
// shared signed multiplier with registered product
// depends on er_pkg

module er_mul
    import er_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MOP_W-1:0]  op_a,
    input  logic signed [MOP_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/ellipse_rasterizer.sv =====
`timescale 1ns / 1ps
// midpoint ellipse rasterizer top level: sequencer, walk state and output register
// depends on er_pkg and er_mul
// start beat: three passes through the multiplier (ST_SQA, ST_SQB, ST_GY), then ST_INIT
// step beat: four pixel beats from ST_EMIT0 to ST_EMIT3, ready again after ST_EMIT3;
// the switch into region 2 first runs ST_T to ST_AB through the multiplier, then ST_DEC;
// a step while idle is dropped; the pixel output register sets the pace
// reset clears the sequencer, the region and the output valid; the walk registers load on start

module ellipse_rasterizer
    import er_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // center_x, center_y, radius_x, radius_y, zero pad
    input  logic [0:0]           s_tuser,  // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // pixel_x, pixel_y, zero pad
    output logic                 m_tlast,
    output logic [0:0]           m_tuser   // done_res
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQA, ST_SQB, ST_GY, ST_INIT,
        ST_T, ST_TT, ST_Y, ST_YY, ST_AB, ST_DEC,
        ST_EMIT0, ST_EMIT1, ST_EMIT2, ST_EMIT3
    } state_t;

    typedef enum logic [1:0] {
        RG_IDLE, RG_ONE, RG_TWO
    } region_t;

    state_t  state_reg, state_next;
    region_t region_reg, region_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]        m_tdata_reg, m_tdata_next;
    logic                        m_tlast_reg, m_tlast_next;
    logic                        m_tuser_reg, m_tuser_next;

    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic [RADIUS_BITS-1:0]       rad_a_reg, rad_a_next;
    logic [RADIUS_BITS-1:0]       rad_b_reg, rad_b_next;
    logic [SQ_W-1:0]              rx_sq_reg, rx_sq_next;
    logic [SQ_W-1:0]              ry_sq_reg, ry_sq_next;
    logic [CURX_W-1:0]            cur_x_reg, cur_x_next;
    logic signed [CURY_W-1:0]     cur_y_reg, cur_y_next;
    logic [CURX_W-1:0]            px_reg, px_next;
    logic signed [CURY_W-1:0]     py_reg, py_next;
    logic signed [GRAD_W-1:0]     grad_x_reg, grad_x_next;
    logic signed [GRAD_W-1:0]     grad_y_reg, grad_y_next;
    logic signed [GRAD_W-1:0]     tmp_reg, tmp_next;
    logic signed [DEC_W-1:0]      decision_reg, decision_next;
    logic signed [DEC_W-1:0]      acc_reg, acc_next;
    logic                         use_gx_reg, use_gx_next;
    logic                         use_gy_reg, use_gy_next;
    logic                         fin_reg, fin_next;

    logic signed [MOP_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    logic                     out_free;
    logic                     out_load;
    logic                     out_last;
    logic                     out_done;
    logic [PIX_W-1:0]         beat_x, beat_y;

    logic signed [GRAD_W-1:0] two_rx, two_ry, rx_g, ry_g;
    logic signed [MOP_W-1:0]  op_rad_a, op_rad_b, op_rx, op_ry, op_t, op_ym1, op_prod;
    logic signed [CURY_W:0]   ym1;
    logic signed [DEC_W-1:0]  prod_dec, prod_dec4, tmp_dec4;
    logic signed [SUM_W-1:0]  cx_s, cy_s, px_s, py_s;
    logic signed [SUM_W-1:0]  sum_x, dif_x, sum_y, dif_y;

    er_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign two_rx = {{(GRAD_W-SQ_W-1){1'b0}}, rx_sq_reg, 1'b0};
    assign two_ry = {{(GRAD_W-SQ_W-1){1'b0}}, ry_sq_reg, 1'b0};
    assign rx_g   = {{(GRAD_W-SQ_W){1'b0}}, rx_sq_reg};
    assign ry_g   = {{(GRAD_W-SQ_W){1'b0}}, ry_sq_reg};

    assign ym1      = {cur_y_reg[CURY_W-1], cur_y_reg} - (CURY_W+1)'(1);
    assign op_rad_a = {{(MOP_W-RADIUS_BITS){1'b0}}, rad_a_reg};
    assign op_rad_b = {{(MOP_W-RADIUS_BITS){1'b0}}, rad_b_reg};
    assign op_rx    = {{(MOP_W-SQ_W){1'b0}}, rx_sq_reg};
    assign op_ry    = {{(MOP_W-SQ_W){1'b0}}, ry_sq_reg};
    assign op_t     = {{(MOP_W-CURX_W-1){1'b0}}, cur_x_reg, 1'b1};
    assign op_ym1   = {{(MOP_W-CURY_W-1){ym1[CURY_W]}}, ym1};
    assign op_prod  = prod[MOP_W-1:0];

    assign prod_dec  = prod[DEC_W-1:0];
    assign prod_dec4 = {prod[DEC_W-3:0], 2'b00};
    assign tmp_dec4  = {{(DEC_W-GRAD_W-2){tmp_reg[GRAD_W-1]}}, tmp_reg, 2'b00};

    // pixel coordinates, wrapped to the pixel width
    assign cx_s  = {{(SUM_W-COORD_BITS){cx_reg[COORD_BITS-1]}}, cx_reg};
    assign cy_s  = {{(SUM_W-COORD_BITS){cy_reg[COORD_BITS-1]}}, cy_reg};
    assign px_s  = {{(SUM_W-CURX_W){1'b0}}, px_reg};
    assign py_s  = {{(SUM_W-CURY_W){py_reg[CURY_W-1]}}, py_reg};
    assign sum_x = cx_s + px_s;
    assign dif_x = cx_s - px_s;
    assign sum_y = cy_s + py_s;
    assign dif_y = cy_s - py_s;

    always_comb begin
        beat_x = dif_x[PIX_W-1:0];
        beat_y = dif_y[PIX_W-1:0];
        if (state_reg == ST_EMIT0 || state_reg == ST_EMIT1) begin
            beat_x = sum_x[PIX_W-1:0];
        end
        if (state_reg == ST_EMIT0 || state_reg == ST_EMIT2) begin
            beat_y = sum_y[PIX_W-1:0];
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        region_next   = region_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        rad_a_next    = rad_a_reg;
        rad_b_next    = rad_b_reg;
        rx_sq_next    = rx_sq_reg;
        ry_sq_next    = ry_sq_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        grad_x_next   = grad_x_reg;
        grad_y_next   = grad_y_reg;
        tmp_next      = tmp_reg;
        decision_next = decision_reg;
        acc_next      = acc_reg;
        use_gx_next   = use_gx_reg;
        use_gy_next   = use_gy_reg;
        fin_next      = fin_reg;
        mul_a         = '0;
        mul_b         = '0;
        out_load      = 1'b0;
        out_last      = 1'b0;
        out_done      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == MODE_START) begin
                        cx_next     = s_tdata[COORD_BITS-1:0];
                        cy_next     = s_tdata[2*COORD_BITS-1:COORD_BITS];
                        rad_a_next  = s_tdata[2*COORD_BITS +: RADIUS_BITS];
                        rad_b_next  = s_tdata[2*COORD_BITS+RADIUS_BITS +: RADIUS_BITS];
                        cur_x_next  = '0;
                        cur_y_next  = {{(CURY_W-RADIUS_BITS){1'b0}},
                                       s_tdata[2*COORD_BITS+RADIUS_BITS +: RADIUS_BITS]};
                        grad_x_next = '0;
                        state_next  = ST_SQA;
                    end else if (region_reg != RG_IDLE) begin
                        px_next = cur_x_reg;
                        py_next = cur_y_reg;
                        if (region_reg == RG_ONE && grad_x_reg >= grad_y_reg) begin
                            state_next = ST_T;
                        end else begin
                            state_next = ST_EMIT0;
                        end
                    end
                end
            end
            ST_SQA: begin
                mul_a      = op_rad_a;
                mul_b      = op_rad_a;
                state_next = ST_SQB;
            end
            ST_SQB: begin
                rx_sq_next = prod[SQ_W-1:0];
                mul_a      = op_rad_b;
                mul_b      = op_rad_b;
                state_next = ST_GY;
            end
            ST_GY: begin
                ry_sq_next = prod[SQ_W-1:0];
                mul_a      = op_rx;
                mul_b      = op_rad_b;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                grad_y_next   = {prod[GRAD_W-2:0], 1'b0};
                decision_next = {{(DEC_W-SQ_W-2){1'b0}}, ry_sq_reg, 2'b00} - prod_dec4
                              + {{(DEC_W-SQ_W){1'b0}}, rx_sq_reg};
                region_next   = RG_ONE;
                state_next    = ST_IDLE;
            end
            // region 2 entry: b^2 (2x+1)^2 + 4 a^2 (y-1)^2 - 4 a^2 b^2
            ST_T: begin
                mul_a      = op_t;
                mul_b      = op_t;
                state_next = ST_TT;
            end
            ST_TT: begin
                mul_a      = op_ry;
                mul_b      = op_prod;
                state_next = ST_Y;
            end
            ST_Y: begin
                acc_next   = prod_dec;
                mul_a      = op_ym1;
                mul_b      = op_ym1;
                state_next = ST_YY;
            end
            ST_YY: begin
                mul_a      = op_rx;
                mul_b      = op_prod;
                state_next = ST_AB;
            end
            ST_AB: begin
                acc_next   = acc_reg + prod_dec4;
                mul_a      = op_rx;
                mul_b      = op_ry;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                decision_next = acc_reg - prod_dec4;
                region_next   = RG_TWO;
                state_next    = ST_EMIT0;
            end
            // walk update spread over the four pixel beats
            ST_EMIT0: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (region_reg == RG_ONE) begin
                        cur_x_next  = cur_x_reg + CURX_W'(1);
                        grad_x_next = grad_x_reg + two_ry;
                        use_gx_next = 1'b1;
                        use_gy_next = !decision_reg[DEC_W-1];
                        fin_next    = 1'b0;
                        if (!decision_reg[DEC_W-1]) begin
                            cur_y_next  = cur_y_reg - CURY_W'(1);
                            grad_y_next = grad_y_reg - two_rx;
                        end
                    end else begin
                        cur_y_next  = cur_y_reg - CURY_W'(1);
                        grad_y_next = grad_y_reg - two_rx;
                        use_gy_next = 1'b1;
                        use_gx_next = !(decision_reg > 0);
                        fin_next    = (cur_y_reg == '0);
                        if (!(decision_reg > 0)) begin
                            cur_x_next  = cur_x_reg + CURX_W'(1);
                            grad_x_next = grad_x_reg + two_ry;
                        end
                    end
                    state_next = ST_EMIT1;
                end
            end
            ST_EMIT1: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    tmp_next   = (use_gx_reg ? grad_x_reg : '0)
                               - (use_gy_reg ? grad_y_reg : '0)
                               + ((region_reg == RG_ONE) ? ry_g : rx_g);
                    state_next = ST_EMIT2;
                end
            end
            ST_EMIT2: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    decision_next = decision_reg + tmp_dec4;
                    state_next    = ST_EMIT3;
                end
            end
            ST_EMIT3: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    out_done = fin_reg;
                    if (fin_reg) begin
                        region_next = RG_IDLE;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(M_TDATA_W-2*PIX_W){1'b0}}, beat_y, beat_x};
            m_tlast_next  = out_last;
            m_tuser_next  = out_done;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        rad_a_reg    <= rad_a_next;
        rad_b_reg    <= rad_b_next;
        rx_sq_reg    <= rx_sq_next;
        ry_sq_reg    <= ry_sq_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        grad_x_reg   <= grad_x_next;
        grad_y_reg   <= grad_y_next;
        tmp_reg      <= tmp_next;
        decision_reg <= decision_next;
        acc_reg      <= acc_next;
        use_gx_reg   <= use_gx_next;
        use_gy_reg   <= use_gy_next;
        fin_reg      <= fin_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
        m_tuser_reg  <= m_tuser_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            region_reg   <= RG_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            region_reg   <= region_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ===== hw/rtl/er_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the ellipse rasterizer, bound to the top level
// depends on er_pkg and ellipse_rasterizer

module er_checker
    import er_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [0:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic [0:0]           m_tuser
);

    // done only on the last pixel of a step
    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("done flag on a beat that is not the last of its step");

    // a start beat keeps the block busy while the squares are formed
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == MODE_START) |=> !s_tready)
        else $error("input ready right after a start beat");

    // no new input while a step still has pixels to deliver
    a_busy_mid_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a step");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("output beat changed while stalled");

endmodule

bind ellipse_rasterizer er_checker u_er_checker (.*);
